// ===== design/sct_pkg.sv =====
// Types, codes and character constants for the shell command tokenizer.
// No dependencies; used by shell_command_tokenizer.
package sct_pkg;

    // input word codes
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_END  = 1'b1;

    // result word kinds
    localparam logic [1:0] KIND_BYTE    = 2'd0;
    localparam logic [1:0] KIND_END     = 2'd1;
    localparam logic [1:0] KIND_SUMMARY = 2'd2;

    // flag bit positions
    localparam int FLAG_CHAIN = 0;
    localparam int FLAG_PIPE  = 1;
    localparam int FLAG_SUB   = 2;
    localparam int FLAG_REDIR = 3;
    localparam int FLAG_W     = 4;

    localparam int CNT_W = 16;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // result queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int MAX_RES     = 3;
    localparam int PUSH_W      = $clog2(MAX_RES + 1);

    // characters
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_LPAR   = 8'h28;
    localparam logic [7:0] CH_RPAR   = 8'h29;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_BTICK  = 8'h60;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] ASCII_MAX = 8'd127;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0]       kind;
        logic [7:0]       token_byte;
        logic             chain_seen;
        logic             pipe_seen;
        logic             subshell_seen;
        logic             redirect_seen;
        logic [CNT_W-1:0] tokens_total;
        logic             final_res;
    } t_out_item;

endpackage

// ===== design/shell_command_tokenizer.sv =====
// Shell command tokenizer: quote/escape tracking, token split, flag gathering.
// Depends on sct_pkg for word types, codes and character constants.
//
// A command enters as one byte word per cycle while o_in_stall is low, then
// an end word. Each accepted byte word is resolved in the cycle it is
// accepted, using the previously held byte as the current character and the
// new byte as its lookahead, so the results for a byte come out once its
// successor (or the end word) arrives. A byte word yields at most one result
// word, an end word up to three (a pending token byte or token end, the
// closing token end, and the summary). Results go into a 4-entry queue that
// drives the output directly; output words are presented one per cycle while
// the output is not stalled. The input stalls while the queue holds two or
// more words, so byte words flow at one per cycle when the output is not
// stalled. All parsing state returns to its reset value after each summary.
module shell_command_tokenizer
    import sct_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_data,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_item o_out_data,
    input  logic      i_out_stall
);

    logic [7:0]        r_held_byte, n_held_byte;
    logic              r_held_valid, n_held_valid;
    logic              r_in_single, n_in_single;
    logic              r_in_double, n_in_double;
    logic              r_quoted_mark, n_quoted_mark;
    logic              r_token_open, n_token_open;
    logic [FLAG_W-1:0] r_flag_bits, n_flag_bits;
    logic [CNT_W-1:0]  r_token_counter, n_token_counter;

    t_out_item         r_queue [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    t_out_item         w_res [MAX_RES];
    logic [PUSH_W-1:0] w_push;
    logic              w_accept, w_pop;
    logic              w_has_next, w_consumed;
    logic [7:0]        w_c, w_nx;

    assign o_in_stall  = r_count > QCNT_W'(QUEUE_DEPTH - MAX_RES);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_count != '0;
    assign o_out_data  = r_queue[r_rd_ptr];
    assign w_pop       = o_out_valid && !i_out_stall;

    assign w_c        = r_held_byte;
    assign w_has_next = i_in_data.cmd == CMD_BYTE;
    assign w_nx       = w_has_next ? i_in_data.data_byte : 8'd0;

    always_comb begin
        n_held_byte     = r_held_byte;
        n_held_valid    = r_held_valid;
        n_in_single     = r_in_single;
        n_in_double     = r_in_double;
        n_quoted_mark   = r_quoted_mark;
        n_token_open    = r_token_open;
        n_flag_bits     = r_flag_bits;
        n_token_counter = r_token_counter;
        w_push          = '0;
        w_consumed      = 1'b0;
        for (int k = 0; k < MAX_RES; k++) begin
            w_res[k] = '0;
        end

        // current character, lookahead from the incoming word
        if (w_accept && r_held_valid) begin
            if (w_c > ASCII_MAX) begin
                n_flag_bits[FLAG_CHAIN] = 1'b1;
            end
            if (w_c == CH_DOLLAR && w_has_next && w_nx == CH_SQUOTE) begin
                n_flag_bits[FLAG_CHAIN] = 1'b1;
            end else if (w_c == CH_BSLASH && !r_in_single) begin
                n_flag_bits[FLAG_CHAIN] = 1'b1;
                w_consumed = w_has_next;
            end else if (w_c == CH_SQUOTE && !r_in_double) begin
                n_in_single   = !r_in_single;
                n_quoted_mark = 1'b1;
            end else if (w_c == CH_DQUOTE && !r_in_single) begin
                n_in_double   = !r_in_double;
                n_quoted_mark = 1'b1;
            end else if (r_in_single || r_in_double) begin
                w_res[0].kind       = KIND_BYTE;
                w_res[0].token_byte = w_c;
                w_push              = PUSH_W'(1);
                n_token_open        = 1'b1;
            end else if (w_c inside {CH_SPACE, [CH_TAB:CH_CR]}) begin
                if (r_token_open || r_quoted_mark) begin
                    w_res[0].kind = KIND_END;
                    w_push        = PUSH_W'(1);
                    if (r_token_counter != CNT_MAX) begin
                        n_token_counter = r_token_counter + CNT_W'(1);
                    end
                    n_token_open  = 1'b0;
                    n_quoted_mark = 1'b0;
                end
            end else if (w_c inside {CH_SEMI, CH_PIPE, CH_AMP, CH_LPAR, CH_RPAR,
                                     CH_DOLLAR, CH_BTICK, CH_GT, CH_LT}) begin
                case (w_c)
                    CH_SEMI, CH_AMP: begin
                        n_flag_bits[FLAG_CHAIN] = 1'b1;
                    end
                    CH_PIPE: begin
                        if (w_has_next && w_nx == CH_PIPE) begin
                            n_flag_bits[FLAG_CHAIN] = 1'b1;
                        end else begin
                            n_flag_bits[FLAG_PIPE] = 1'b1;
                        end
                    end
                    CH_DOLLAR: begin
                        if (w_has_next && w_nx == CH_LPAR) begin
                            n_flag_bits[FLAG_SUB] = 1'b1;
                        end
                    end
                    CH_BTICK, CH_LPAR, CH_RPAR: begin
                        n_flag_bits[FLAG_SUB] = 1'b1;
                    end
                    default: begin
                        n_flag_bits[FLAG_REDIR] = 1'b1;
                    end
                endcase
                // quoted mark is left as is here
                if (r_token_open) begin
                    w_res[0].kind = KIND_END;
                    w_push        = PUSH_W'(1);
                    if (r_token_counter != CNT_MAX) begin
                        n_token_counter = r_token_counter + CNT_W'(1);
                    end
                    n_token_open = 1'b0;
                end
                w_consumed = w_has_next && w_nx == w_c &&
                             (w_c == CH_AMP || w_c == CH_PIPE ||
                              w_c == CH_GT || w_c == CH_LT);
            end else begin
                w_res[0].kind       = KIND_BYTE;
                w_res[0].token_byte = w_c;
                w_push              = PUSH_W'(1);
                n_token_open        = 1'b1;
            end
        end

        if (w_accept) begin
            if (i_in_data.cmd == CMD_BYTE) begin
                if (r_held_valid && w_consumed) begin
                    n_held_valid = 1'b0;
                end else begin
                    n_held_byte  = i_in_data.data_byte;
                    n_held_valid = 1'b1;
                end
            end else begin
                if (n_in_single || n_in_double) begin
                    n_flag_bits[FLAG_CHAIN] = 1'b1;
                end
                if (n_token_open || n_quoted_mark) begin
                    w_res[w_push].kind = KIND_END;
                    w_push = w_push + PUSH_W'(1);
                    if (n_token_counter != CNT_MAX) begin
                        n_token_counter = n_token_counter + CNT_W'(1);
                    end
                end
                w_res[w_push].kind          = KIND_SUMMARY;
                w_res[w_push].chain_seen    = n_flag_bits[FLAG_CHAIN];
                w_res[w_push].pipe_seen     = n_flag_bits[FLAG_PIPE];
                w_res[w_push].subshell_seen = n_flag_bits[FLAG_SUB];
                w_res[w_push].redirect_seen = n_flag_bits[FLAG_REDIR];
                w_res[w_push].tokens_total  = n_token_counter;
                w_res[w_push].final_res     = 1'b1;
                w_push = w_push + PUSH_W'(1);

                n_held_byte     = '0;
                n_held_valid    = 1'b0;
                n_in_single     = 1'b0;
                n_in_double     = 1'b0;
                n_quoted_mark   = 1'b0;
                n_token_open    = 1'b0;
                n_flag_bits     = '0;
                n_token_counter = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_byte     <= '0;
            r_held_valid    <= 1'b0;
            r_in_single     <= 1'b0;
            r_in_double     <= 1'b0;
            r_quoted_mark   <= 1'b0;
            r_token_open    <= 1'b0;
            r_flag_bits     <= '0;
            r_token_counter <= '0;
            r_wr_ptr        <= '0;
            r_rd_ptr        <= '0;
            r_count         <= '0;
        end else begin
            r_held_byte     <= n_held_byte;
            r_held_valid    <= n_held_valid;
            r_in_single     <= n_in_single;
            r_in_double     <= n_in_double;
            r_quoted_mark   <= n_quoted_mark;
            r_token_open    <= n_token_open;
            r_flag_bits     <= n_flag_bits;
            r_token_counter <= n_token_counter;
            r_wr_ptr        <= r_wr_ptr + QPTR_W'(w_push);
            r_rd_ptr        <= r_rd_ptr + QPTR_W'(w_pop);
            r_count         <= r_count + QCNT_W'(w_push) - QCNT_W'(w_pop);
        end
    end

    // result queue storage
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_RES; k++) begin
            if (PUSH_W'(k) < w_push) begin
                r_queue[r_wr_ptr + QPTR_W'(k)] <= w_res[k];
            end
        end
    end

`ifndef SYNTHESIS
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("result queue overflow");

    a_push_needs_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |-> w_push == '0)
        else $error("result pushed without an accepted word");

    a_byte_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_data.cmd == CMD_BYTE) |-> w_push <= PUSH_W'(1))
        else $error("byte word produced more than one result");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_data.cmd == CMD_END) |=>
            (!r_held_valid && r_token_counter == '0 && r_flag_bits == '0 &&
             !r_in_single && !r_in_double))
        else $error("state not cleared after end of command");

    a_end_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_data.cmd == CMD_END) |-> w_push != '0)
        else $error("end of command produced no summary");
`endif

endmodule
